// File: src/resizable_ring_fifo_core_assert.svh
// Assertion macros for the resizable ring FIFO core.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef RESIZABLE_RING_FIFO_CORE_ASSERT_SVH
`define RESIZABLE_RING_FIFO_CORE_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`define RRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define RRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/rrf_pkg.sv
// Shared types and constants for the resizable ring FIFO core.
// No dependencies; imported by rrf_cell and resizable_ring_fifo_core.
package rrf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DEPTH_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Capacity after reset
  localparam int CAP_RESET = 16;

  // Fixed field widths of the word channels
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int FIELD_W = 7;

  // Register port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_INIT_CAP = 2'd0;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_GROW   = 2'd2,
    CMD_SHRINK = 2'd3
  } rrf_cmd_e;

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] write_data;
  } rrf_in_t;

  // Result word
  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  read_data;
    logic               is_empty;
    logic [FIELD_W-1:0] occupancy;
    logic [FIELD_W-1:0] capacity;
  } rrf_out_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic shift;  // take the neighbor's word (pop the head of the chain)
    logic load;   // this cell is the tail slot: take the pushed word
  } rrf_cell_ctrl_t;

endpackage

// File: src/rrf_cell.sv
// One storage cell of the FIFO chain: holds a word, shifts toward the head.
// Depends on rrf_pkg for the cell control struct.
module rrf_cell
  import rrf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  rrf_cell_ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q;

  // Shift takes the younger neighbor's word; load takes the pushed word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= next_i;
    end else if (ctrl_i.load) begin
      data_q <= wdata_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: src/resizable_ring_fifo_core.sv
// Resizable FIFO core: a chain of word cells, cell 0 always holds the oldest word.
// Result word: registered for each accepted command, valid in the cycle after it.
// Throughput: one command per cycle; the single output register sets this figure,
// and input stalls only while a result waits and out_stall_i is high.
// Reset: queue empty, capacity 16 (limited to MAX_DEPTH); cell contents are not cleared.
// Depends on rrf_pkg, rrf_cell and resizable_ring_fifo_core_assert.svh.
module resizable_ring_fifo_core
  import rrf_pkg::*;
#(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrf_in_t            in_word_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rrf_out_t           out_word_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int ADDR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int CAP_INIT = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [FIELD_W-1:0]    cfg_q;
  logic                  out_valid_q;
  rrf_out_t              out_q;

  logic                  accept;
  logic                  cfg_wr;
  logic                  full;
  logic                  ok;
  logic                  do_shift;
  logic                  do_load;
  logic [CNT_W-1:0]      cfg_cap;
  logic [CMP_W-1:0]      cfg_val;
  logic [DATA_WIDTH-1:0] wdata;

  rrf_cell_ctrl_t        cell_ctrl [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] cell_data [MAX_DEPTH];

  // Handshakes
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr == REG_INIT_CAP);
  assign pready     = 1'b1;
  assign prdata     = (paddr == REG_INIT_CAP) ? PDATA_W'(cfg_q) : '0;

  // Capacity from the register write, limited to 1..MAX_DEPTH
  always_comb begin
    cfg_val = CMP_W'(pwdata[FIELD_W-1:0]);
    if (cfg_val == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_val > CMP_W'(MAX_DEPTH)) begin
      cfg_cap = CNT_W'(MAX_DEPTH);
    end else begin
      cfg_cap = CNT_W'(cfg_val);
    end
  end

  // Command decode and next counters
  assign full  = (count_q >= cap_q);
  assign wdata = DATA_WIDTH'(in_word_i.write_data);

  always_comb begin
    ok       = 1'b0;
    do_shift = 1'b0;
    do_load  = 1'b0;
    count_d  = count_q;
    cap_d    = cap_q;
    case (in_word_i.command)
      CMD_WRITE: begin
        if (!full) begin
          do_load = 1'b1;
          count_d = count_q + 1'b1;
          ok      = 1'b1;
        end
      end
      CMD_READ: begin
        if (count_q != '0) begin
          do_shift = 1'b1;
          count_d  = count_q - 1'b1;
          ok       = 1'b1;
        end
      end
      CMD_GROW: begin
        if (cap_q < CNT_W'(MAX_DEPTH)) begin
          cap_d = cap_q + 1'b1;
          ok    = 1'b1;
        end
      end
      CMD_SHRINK: begin
        if (cap_q > CNT_W'(1)) begin
          // full queue drops its oldest word to keep order
          if (full) begin
            do_shift = 1'b1;
            count_d  = count_q - 1'b1;
          end
          cap_d = cap_q - 1'b1;
          ok    = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Cell controls: shift is broadcast, load hits the tail slot only
  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      cell_ctrl[i].shift = accept && do_shift;
      cell_ctrl[i].load  = accept && do_load && (count_q[ADDR_W-1:0] == ADDR_W'(i));
    end
  end

  // Chain of cells, cell 0 is the head
  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] next_data;
    if (g == MAX_DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    rrf_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[g]),
      .wdata_i(wdata),
      .next_i (next_data),
      .data_o (cell_data[g])
    );
  end

  // Counters and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CNT_W'(CAP_INIT);
      cfg_q   <= FIELD_W'(CAP_RESET);
    end else if (cfg_wr) begin
      count_q <= '0;
      cap_q   <= cfg_cap;
      cfg_q   <= pwdata[FIELD_W-1:0];
    end else if (accept) begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.ok        <= ok;
      out_q.read_data <= (ok && (in_word_i.command == CMD_READ)) ? WORD_W'(cell_data[0]) : '0;
      out_q.is_empty  <= (count_d == '0);
      out_q.occupancy <= FIELD_W'(count_d);
      out_q.capacity  <= FIELD_W'(cap_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  `include "resizable_ring_fifo_core_assert.svh"

  `RRF_ASSERT(a_count_le_cap, count_q <= cap_q, "occupancy above capacity")
  `RRF_ASSERT(a_cap_range, (cap_q >= CNT_W'(1)) && (cap_q <= CNT_W'(MAX_DEPTH)), "capacity out of range")
  `RRF_ASSERT(a_push_counts, (accept && (in_word_i.command == CMD_WRITE) && !full) |=> (count_q == $past(count_q) + 1'b1), "push did not raise occupancy")
  `RRF_ASSERT(a_empty_pop, (accept && (in_word_i.command == CMD_READ) && (count_q == '0)) |=> (out_valid_q && !out_q.ok && (out_q.read_data == '0)), "pop of empty queue reported data")
  `RRF_ASSERT_ALWAYS(a_stall_only_valid, in_stall_o |-> out_valid_q, "input stalled with no pending result")

endmodule

// File: dv/resizable_ring_fifo_core_tb.sv
// Self-checking testbench for resizable_ring_fifo_core: directed table, then random phases.
// Depends on rrf_pkg and the core; its queue model predicts each result not typed in a row.
module resizable_ring_fifo_core_tb;
  import rrf_pkg::*;

  localparam int DEPTH     = MAX_DEPTH_DEF;
  localparam int LIMIT     = 400000;
  localparam int N_DIR     = 25;
  localparam int N_PHASES  = 14;
  localparam int PHASE_LEN = 96;

  // One row of the directed table; cfg rows write the capacity register with data
  typedef struct {
    bit                 cfg;
    rrf_cmd_e           cmd;
    logic [WORD_W-1:0]  data;
    bit                 typed;
    logic               ok;
    logic [WORD_W-1:0]  rd;
    logic               emp;
    logic [FIELD_W-1:0] occ;
    logic [FIELD_W-1:0] cap;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  rrf_in_t            in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  rrf_out_t           out_word_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Typed expectation travels with the word it belongs to
  bit       use_typed;
  rrf_out_t typed_word;

  // Queue model state
  logic [WORD_W-1:0] ring_words [DEPTH];
  int                ring_head;
  int                ring_count;
  int                ring_cap;
  rrf_out_t          pending_results [$];

  int       fail_count;
  int       cycle_count;
  int       in_idle_max;
  int       out_idle_max;
  dir_row_t dir_rows [N_DIR];

  resizable_ring_fifo_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Capacity register write: low 7 bits, clamped to 1..DEPTH, queue emptied
  function automatic void set_capacity(input logic [PDATA_W-1:0] v);
    int c;
    c = int'(v[FIELD_W-1:0]);
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    ring_cap   = c;
    ring_head  = 0;
    ring_count = 0;
  endfunction

  // Run one command on the queue model and return the result word it gives
  function automatic rrf_out_t fifo_step(input rrf_in_t w);
    rrf_out_t r;
    r = '0;
    case (rrf_cmd_e'(w.command))
      CMD_WRITE: begin
        if (ring_count < ring_cap) begin
          ring_words[(ring_head + ring_count) % DEPTH] = w.write_data;
          ring_count++;
          r.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (ring_count > 0) begin
          r.read_data = ring_words[ring_head];
          ring_head   = (ring_head + 1) % DEPTH;
          ring_count--;
          r.ok = 1'b1;
        end
      end
      CMD_GROW: begin
        if (ring_cap < DEPTH) begin
          ring_cap++;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (ring_cap > 1) begin
          // full queue: drop the oldest word first
          if (ring_count >= ring_cap) begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
          end
          ring_cap--;
          r.ok = 1'b1;
        end
      end
    endcase
    r.is_empty  = (ring_count == 0);
    r.occupancy = FIELD_W'(ring_count);
    r.capacity  = FIELD_W'(ring_cap);
    return r;
  endfunction

  // Monitor: check accepted results, predict accepted commands, track register writes
  always @(posedge clk_i) begin : monitor
    rrf_out_t want;
    rrf_out_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: %h", $time, out_word_o);
        end else begin
          want = pending_results.pop_front();
          if (out_word_o.ok !== want.ok) begin
            fail_count++;
            $display("%0t: ok expected %0d got %0d", $time, want.ok, out_word_o.ok);
          end
          if (out_word_o.read_data !== want.read_data) begin
            fail_count++;
            $display("%0t: read_data expected %h got %h", $time, want.read_data,
                     out_word_o.read_data);
          end
          if (out_word_o.is_empty !== want.is_empty) begin
            fail_count++;
            $display("%0t: is_empty expected %0d got %0d", $time, want.is_empty,
                     out_word_o.is_empty);
          end
          if (out_word_o.occupancy !== want.occupancy) begin
            fail_count++;
            $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                     out_word_o.occupancy);
          end
          if (out_word_o.capacity !== want.capacity) begin
            fail_count++;
            $display("%0t: capacity expected %0d got %0d", $time, want.capacity,
                     out_word_o.capacity);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        got = fifo_step(in_word_i);
        pending_results.push_back(use_typed ? typed_word : got);
      end
      if (psel && penable && pwrite && pready && paddr == REG_INIT_CAP) begin
        set_capacity(pwdata);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall before each word, none in some phases
  initial begin : result_sink
    int n;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      n = $urandom_range(0, out_idle_max);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one command word after a random gap; valid stays up if the next gap is zero
  task automatic push_cmd(input rrf_in_t w, input bit typed, input rrf_out_t tv);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    use_typed  <= typed;
    typed_word <= tv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register write once the core has drained
  task automatic write_capacity(input logic [PDATA_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_INIT_CAP;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    int          ph;
    int          k;
    int          r;
    int          t_w;
    int          t_r;
    int          t_g;
    logic [31:0] v;
    logic [31:0] d;
    rrf_cmd_e    cmd;
    rrf_in_t     w;
    rrf_out_t    tv;
    dir_row_t    row;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_word_i    <= '0;
    use_typed    <= 1'b0;
    typed_word   <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    fail_count   = 0;
    cycle_count  = 0;
    in_idle_max  = 9;
    out_idle_max = 9;
    ring_head    = 0;
    ring_count   = 0;
    ring_cap     = CAP_RESET;

    // cfg, cmd, data, typed, ok, read_data, is_empty, occupancy, capacity
    dir_rows = '{
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 7'd0, 7'd16},
      '{1'b0, CMD_SHRINK, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 7'd0, 7'd15},
      '{1'b0, CMD_GROW,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 7'd0, 7'd16},
      '{1'b0, CMD_WRITE,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 7'd1, 7'd16},
      '{1'b0, CMD_WRITE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 7'd2, 7'd16},
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 7'd1, 7'd16},
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 7'd0, 7'd16},
      '{1'b1, CMD_WRITE,  32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_SHRINK, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 7'd0, 7'd1},
      '{1'b0, CMD_WRITE,  32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 7'd1, 7'd1},
      '{1'b0, CMD_WRITE,  32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 7'd1, 7'd1},
      '{1'b0, CMD_GROW,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 7'd1, 7'd2},
      '{1'b0, CMD_WRITE,  32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_SHRINK, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b1, CMD_WRITE,  32'h0000_007F, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_GROW,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 7'd0, 7'd64},
      '{1'b0, CMD_WRITE,  32'h8000_0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b1, CMD_WRITE,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 7'd0, 7'd1},
      '{1'b1, CMD_WRITE,  32'hFFFF_FFC8, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_SHRINK, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_WRITE,  32'h7FFF_FFFE, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b0, CMD_READ,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0},
      '{1'b1, CMD_WRITE,  32'h0000_0010, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 7'd0, 7'd0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (k = 0; k < N_DIR; k++) begin
      row = dir_rows[k];
      if (row.cfg) begin
        write_capacity(row.data);
      end else begin
        w.command    = row.cmd;
        w.write_data = row.data;
        tv           = '{row.ok, row.rd, row.emp, row.occ, row.cap};
        push_cmd(w, row.typed, tv);
      end
    end

    // Random phases: capacity setting, command mix and idling change per phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      in_idle_max  = (ph % 3 == 1) ? 0 : 9;
      out_idle_max = (ph % 4 == 2) ? 0 : 9;
      case (ph % 4)
        0:       v = $urandom_range(1, 8);
        1:       v = $urandom_range(0, 127);
        2:       v = $urandom();
        default: v = (ph == 3) ? 32'd64 : (ph == 7) ? 32'd127 : $urandom_range(33, 64);
      endcase
      write_capacity(v);
      // thresholds: write below t_w, read below t_r, grow below t_g, else shrink
      case (ph % 4)
        0:       begin t_w = 55; t_r = 75; t_g = 88; end
        1:       begin t_w = 25; t_r = 75; t_g = 85; end
        2:       begin t_w = 40; t_r = 80; t_g = 90; end
        default: begin t_w = 85; t_r = 90; t_g = 95; end
      endcase
      for (k = 0; k < PHASE_LEN; k++) begin
        r = $urandom_range(0, 99);
        if (r < t_w)      cmd = CMD_WRITE;
        else if (r < t_r) cmd = CMD_READ;
        else if (r < t_g) cmd = CMD_GROW;
        else              cmd = CMD_SHRINK;
        d = $urandom();
        r = $urandom_range(0, 15);
        if (r == 0)      d = '1;
        else if (r == 1) d = '0;
        w.command    = cmd;
        w.write_data = d;
        push_cmd(w, 1'b0, '0);
      end
    end

    // Drain and report
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
